// File: hdl/double_ended_queue_engine_top_defines.svh
// assertion macros shared by the queue engine
`ifndef DOUBLE_ENDED_QUEUE_ENGINE_TOP_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_ENGINE_TOP_DEFINES_SVH

// same-cycle implication, sampled on the rising clock edge
`define DEQ_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/deq_pkg.sv
package deq_pkg;

   localparam int ACTION_W   = 3;
   localparam int VALUE_W    = 32;
   localparam int POSITION_W = 4;
   localparam int COUNT_W    = 5;
   localparam int STATUS_W   = 2;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 40;

   typedef enum logic [ACTION_W-1:0] {
      ACT_PUSH_FRONT = 3'd0,
      ACT_PUSH_BACK  = 3'd1,
      ACT_POP_FRONT  = 3'd2,
      ACT_POP_BACK   = 3'd3,
      ACT_PEEK_FRONT = 3'd4,
      ACT_PEEK_BACK  = 3'd5,
      ACT_READ_INDEX = 3'd6,
      ACT_CLEAR      = 3'd7
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_RANGE = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

   typedef struct packed {
      status_type         status;
      logic [COUNT_W-1:0] entry_count;
      logic               has_data;
   } rsp_info_type;

endpackage

// File: hdl/deq_ram.sv
module deq_ram #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                     clock,
   input  deq_pkg::mem_ctl_type     ctl,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [DATA_WIDTH-1:0]    wr_data,
   output logic [DATA_WIDTH-1:0]    rd_data_ff
);
   import deq_pkg::*;

   logic [DATA_WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

endmodule

// File: hdl/deq_ptr.sv
module deq_ptr #(
   parameter int DEPTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  deq_pkg::action_type               action,
   input  logic [deq_pkg::POSITION_W-1:0]    position,
   output deq_pkg::mem_ctl_type              ctl,
   output logic [$clog2(DEPTH)-1:0]          addr,
   output deq_pkg::rsp_info_type             info
);
   import deq_pkg::*;

   localparam int PW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int SUM_W = PW + 1;

   logic [PW-1:0]    front_ff, front_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [PW-1:0]    front_dec, front_inc, offset;
   logic [CW-1:0]    count_dec;
   logic [SUM_W-1:0] sum, wrapped;
   logic             full, empty, use_front_dec;
   mem_ctl_type      ctl_raw;
   status_type       status;
   logic             has_data;

   assign full      = (count_ff == CW'(DEPTH));
   assign empty     = (count_ff == '0);
   assign front_dec = (front_ff == '0) ? PW'(DEPTH - 1) : front_ff - 1'b1;
   assign front_inc = (front_ff == PW'(DEPTH - 1)) ? '0 : front_ff + 1'b1;
   assign count_dec = count_ff - 1'b1;

   // ring slot of front plus offset, both below DEPTH
   assign sum     = {1'b0, front_ff} + {1'b0, offset};
   assign wrapped = (sum >= SUM_W'(DEPTH)) ? sum - SUM_W'(DEPTH) : sum;
   assign addr    = use_front_dec ? front_dec : wrapped[PW-1:0];

   always_comb begin
      front_in      = front_ff;
      count_in      = count_ff;
      ctl_raw       = '0;
      offset        = '0;
      use_front_dec = 1'b0;
      status        = ST_OK;
      has_data      = 1'b0;
      case (action)
         ACT_PUSH_FRONT: begin
            if (full) begin
               status = ST_FULL;
            end else begin
               use_front_dec = 1'b1;
               front_in      = front_dec;
               count_in      = count_ff + 1'b1;
               ctl_raw.wr_en = 1'b1;
            end
         end
         ACT_PUSH_BACK: begin
            if (full) begin
               status = ST_FULL;
            end else begin
               offset        = PW'(count_ff);
               count_in      = count_ff + 1'b1;
               ctl_raw.wr_en = 1'b1;
            end
         end
         ACT_POP_FRONT, ACT_PEEK_FRONT: begin
            if (empty) begin
               status = ST_EMPTY;
            end else begin
               ctl_raw.rd_en = 1'b1;
               has_data      = 1'b1;
               if (action == ACT_POP_FRONT) begin
                  front_in = front_inc;
                  count_in = count_dec;
               end
            end
         end
         ACT_POP_BACK, ACT_PEEK_BACK: begin
            if (empty) begin
               status = ST_EMPTY;
            end else begin
               offset        = PW'(count_dec);
               ctl_raw.rd_en = 1'b1;
               has_data      = 1'b1;
               if (action == ACT_POP_BACK) begin
                  count_in = count_dec;
               end
            end
         end
         ACT_READ_INDEX: begin
            if (16'(position) >= 16'(count_ff)) begin
               status = ST_RANGE;
            end else begin
               offset        = PW'(position);
               ctl_raw.rd_en = 1'b1;
               has_data      = 1'b1;
            end
         end
         ACT_CLEAR: begin
            front_in = '0;
            count_in = '0;
         end
         default: begin
            front_in = front_ff;
         end
      endcase
   end

   assign ctl.wr_en        = accept & ctl_raw.wr_en;
   assign ctl.rd_en        = accept & ctl_raw.rd_en;
   assign info.status      = status;
   assign info.entry_count = COUNT_W'(count_in);
   assign info.has_data    = has_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         count_ff <= '0;
      end else if (accept) begin
         front_ff <= front_in;
         count_ff <= count_in;
      end
   end

endmodule

// File: hdl/double_ended_queue_engine_top.sv
// results pass the first stage, where the single-port store is used, then the result register
// throughput: one request per cycle unless stalled; at most one store access per request
// the store read register feeds the result register, so reads need no forwarding
// reset clears front pointer, entry count and both pipeline valids
// store contents are not cleared by reset or by a clear request
`include "double_ended_queue_engine_top_defines.svh"

module double_ended_queue_engine_top #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [deq_pkg::REQ_DATA_W-1:0]   req_tdata,  // push_value, position
   input  logic [deq_pkg::ACTION_W-1:0]     req_tuser,  // action
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [deq_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // read_value, entry_count
   output logic [deq_pkg::STATUS_W-1:0]     rsp_tuser   // status
);
   import deq_pkg::*;

   localparam int PW = $clog2(DEPTH);

   logic                  accept, s1_adv;
   logic                  s1_valid_ff, s1_valid_in;
   rsp_info_type          s1_info_ff, info;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]    value_ff;
   logic [COUNT_W-1:0]    count_ff;
   status_type            status_ff;
   mem_ctl_type           ctl;
   logic [PW-1:0]         addr;
   logic [63:0]           push_wide, rd_wide;
   logic [DATA_WIDTH-1:0] wr_data, rd_data;

   assign s1_adv     = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || s1_adv;
   assign accept     = req_tvalid && req_tready;

   assign push_wide = {32'b0, req_tdata[VALUE_W-1:0]};
   assign wr_data   = push_wide[DATA_WIDTH-1:0];

   deq_ptr #(.DEPTH(DEPTH)) u_ptr (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .action   (action_type'(req_tuser)),
      .position (req_tdata[VALUE_W +: POSITION_W]),
      .ctl      (ctl),
      .addr     (addr),
      .info     (info)
   );

   deq_ram #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_ram (
      .clock      (clock),
      .ctl        (ctl),
      .addr       (addr),
      .wr_data    (wr_data),
      .rd_data_ff (rd_data)
   );

   assign rd_wide = 64'(rd_data);

   assign s1_valid_in  = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = (s1_adv && s1_valid_ff) ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_info_ff <= info;
      end
      // store read data is held while the first stage stalls
      if (s1_adv && s1_valid_ff) begin
         value_ff  <= s1_info_ff.has_data ? rd_wide[VALUE_W-1:0] : '0;
         count_ff  <= s1_info_ff.entry_count;
         status_ff <= s1_info_ff.status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b0, count_ff, value_ff};
   assign rsp_tuser  = status_ff;

   `DEQ_ASSERT_IMPLY(a_empty_count, rsp_tvalid && (rsp_tuser == ST_EMPTY), rsp_tdata[36:32] == '0, "empty status with nonzero count")
   `DEQ_ASSERT_IMPLY(a_full_count, rsp_tvalid && (rsp_tuser == ST_FULL), rsp_tdata[36:32] == COUNT_W'(DEPTH), "full status below depth")
   `DEQ_ASSERT_IMPLY(a_err_no_data, rsp_tvalid && (rsp_tuser != ST_OK), rsp_tdata[31:0] == '0, "error result carries data")
   `DEQ_ASSERT_NEXT(a_clear_count, accept && (req_tuser == ACT_CLEAR), s1_info_ff.entry_count == '0, "clear left entries")

endmodule
